### rtl/core/lkv_pkg.sv
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Shared widths, operation codes and the control word that the top level
// broadcasts to every cell of the recency chain.
// ----------------------------------------------------------------------------
package lkv_pkg;

	localparam int KEY_W     = 32;
	localparam int DATA_W    = 32;
	localparam int CAP_W     = 5;
	localparam int DEPTH_DEF = 16;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic {
		OP_PUT = 1'b0,
		OP_GET = 1'b1
	} lkv_op_t;

	// Broadcast to all cells in the execute cycle.
	typedef struct packed {
		logic move;       // promote the hit entry: the hit cell and the cells above it shift
		logic shift_all;  // put miss: every cell takes its upper neighbor's word
	} lkv_ctrl_t;

endpackage

### rtl/core/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// LRU key/value cache
// Fully associative key/value store with least-recently-used replacement,
// built as a chain of cells held in recency order.
// ----------------------------------------------------------------------------
// Usage:
//   A word (op, key, value) is taken at a clock edge where start is high and
//   busy is low. busy is then high for one cycle while all cells compare the
//   key in parallel and the chain shifts. The result word (found, read_value,
//   evicted) appears in the following cycle, marked by done for exactly one cycle;
//   the receiver must take it then, as there is no way to hold it off.
//   A new word cannot be taken while busy is high. The word is registered,
//   then the cells do the parallel compare and one-step shift of the chain.
//   Cell 0 holds the most recently used entry; deeper cells hold older ones.
//   The capacity register must be written through capacity_we and
//   capacity_in_use only while the block is idle; the block itself does not
//   enforce this. Zero acts as one, values above DEPTH as DEPTH. Reset
//   empties the cache (fill count zero) and sets the capacity to 16. Cell
//   contents are not cleared; only the filled cells ever take part.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
	parameter int DEPTH = lkv_pkg::DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             capacity_we,
	input  logic [lkv_pkg::CAP_W-1:0]         capacity_in_use,
	input  logic                             op,
	input  logic signed [lkv_pkg::KEY_W-1:0]  key,
	input  logic signed [lkv_pkg::DATA_W-1:0] value,
	output logic                             done,
	output logic                             found,
	output logic signed [lkv_pkg::DATA_W-1:0] read_value,
	output logic                             evicted
);
	import lkv_pkg::*;

	localparam int FILL_W = $clog2(DEPTH + 1);
	localparam int CW     = (FILL_W > CAP_W) ? FILL_W : CAP_W;

	logic [CAP_W-1:0]  cap_q;
	logic [FILL_W-1:0] fill_q;
	logic              busy_q;
	logic              done_q;
	logic              found_q;
	logic              evicted_q;
	logic [DATA_W-1:0] read_value_q;

	lkv_op_t           op_s1;
	logic [KEY_W-1:0]  key_s1;
	logic [DATA_W-1:0] value_s1;

	logic [KEY_W-1:0]  chain_key [DEPTH+1];
	logic [DATA_W-1:0] chain_val [DEPTH+1];
	logic              chain_hit [DEPTH+1];
	logic [DATA_W-1:0] chain_hv  [DEPTH+1];
	logic [DEPTH-1:0]  match_vec;

	lkv_ctrl_t         ctrl;
	logic              hit;
	logic [DATA_W-1:0] hit_val;
	logic              is_put;
	logic              full;
	logic [CW-1:0]     cap_ext;
	logic [CW-1:0]     cap_eff;
	logic              accept;

	assign accept  = start && !busy_q;
	assign hit     = chain_hit[DEPTH];
	assign hit_val = chain_hv[DEPTH];
	assign is_put  = (op_s1 == OP_PUT);

	assign cap_ext = CW'(cap_q);
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CW'(1);
		end else if (cap_ext > CW'(DEPTH)) begin
			cap_eff = CW'(DEPTH);
		end else begin
			cap_eff = cap_ext;
		end
	end
	assign full = CW'(fill_q) >= cap_eff;

	assign ctrl.move      = busy_q && hit;
	assign ctrl.shift_all = busy_q && is_put && !hit;

	// The word entering the top of the chain: the hit entry on a promote,
	// the new entry on a put miss. A put always carries the new value.
	assign chain_key[0] = key_s1;
	assign chain_val[0] = is_put ? value_s1 : hit_val;
	assign chain_hit[0] = 1'b0;
	assign chain_hv[0]  = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic slot_valid;
		assign slot_valid = fill_q > FILL_W'(i);

		lkv_cell u_cell (
			.clk         (clk),
			.prev_key    (chain_key[i]),
			.prev_val    (chain_val[i]),
			.search_key  (key_s1),
			.slot_valid  (slot_valid),
			.ctrl        (ctrl),
			.hit_in      (chain_hit[i]),
			.hit_val_in  (chain_hv[i]),
			.cell_key    (chain_key[i+1]),
			.cell_val    (chain_val[i+1]),
			.match       (match_vec[i]),
			.hit_out     (chain_hit[i+1]),
			.hit_val_out (chain_hv[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= lkv_op_t'(op);
			key_s1   <= key;
			value_s1 <= value;
		end
		if (busy_q) begin
			found_q      <= hit;
			read_value_q <= (!is_put && hit) ? hit_val : '0;
			evicted_q    <= is_put && !hit && full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_RESET;
			fill_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (capacity_we) begin
				cap_q <= capacity_in_use;
			end
			busy_q <= accept;
			done_q <= busy_q;
			if (busy_q && is_put && !hit) begin
				// When full, the bottom entries fall off and the count lands on capacity.
				fill_q <= full ? FILL_W'(cap_eff) : fill_q + FILL_W'(1);
			end
		end
	end

	assign busy       = busy_q;
	assign done       = done_q;
	assign found      = found_q;
	assign read_value = read_value_q;
	assign evicted    = evicted_q;

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> $onehot0(match_vec))
		else $error("more than one cell matched the search key");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(DEPTH))
		else $error("fill count exceeds depth");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> (done_q && !busy_q))
		else $error("result word did not follow the execute cycle");

	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && evicted_q) |-> !found_q)
		else $error("eviction reported on a hit");

	a_fill_growth: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && hit) |=> $stable(fill_q))
		else $error("fill count changed on a hit");

endmodule

### rtl/core/lkv_cell.sv
// ----------------------------------------------------------------------------
// LRU key/value cache cell
// One slot of the recency chain. Compares its key with the search key,
// passes the hit flag and hit value down the chain and takes the word of
// its upper neighbor when told to shift.
// ----------------------------------------------------------------------------
module lkv_cell (
	input  logic                      clk,
	input  logic [lkv_pkg::KEY_W-1:0]  prev_key,
	input  logic [lkv_pkg::DATA_W-1:0] prev_val,
	input  logic [lkv_pkg::KEY_W-1:0]  search_key,
	input  logic                      slot_valid,
	input  lkv_pkg::lkv_ctrl_t        ctrl,
	input  logic                      hit_in,
	input  logic [lkv_pkg::DATA_W-1:0] hit_val_in,
	output logic [lkv_pkg::KEY_W-1:0]  cell_key,
	output logic [lkv_pkg::DATA_W-1:0] cell_val,
	output logic                      match,
	output logic                      hit_out,
	output logic [lkv_pkg::DATA_W-1:0] hit_val_out
);
	import lkv_pkg::*;

	logic [KEY_W-1:0]  key_q;
	logic [DATA_W-1:0] val_q;
	logic              shift;

	assign match       = slot_valid && (key_q == search_key);
	assign hit_out     = hit_in | match;
	assign hit_val_out = hit_val_in | (match ? val_q : '0);

	// On a promote, a cell shifts when no cell above it matched, which is the
	// hit cell and every younger cell; the hit entry re-enters at the top.
	assign shift = ctrl.shift_all | (ctrl.move & !hit_in);

	always_ff @(posedge clk) begin
		if (shift) begin
			key_q <= prev_key;
			val_q <= prev_val;
		end
	end

	assign cell_key = key_q;
	assign cell_val = val_q;

endmodule
